// ===== rtl/hsl_pkg.sv =====
`default_nettype none

package hsl_pkg;

    localparam int COMP_W  = 8;
    localparam int PV_W    = 16;
    localparam int NUM_W   = 24;
    localparam int SX_W    = 3;
    localparam int H6_W    = 11;
    localparam int DIV_BASE = 255;

    localparam logic [SX_W-1:0] SX_RED_UP    = 3'd0;
    localparam logic [SX_W-1:0] SX_GREEN_TOP = 3'd1;
    localparam logic [SX_W-1:0] SX_BLUE_UP   = 3'd2;
    localparam logic [SX_W-1:0] SX_BLUE_TOP  = 3'd3;
    localparam logic [SX_W-1:0] SX_RED_RISE  = 3'd4;
    localparam logic [SX_W-1:0] SX_RED_TOP   = 3'd5;
    localparam logic [SX_W-1:0] SX_GRAY      = 3'd6;

    typedef struct packed {
        logic [SX_W-1:0]   sx;
        logic              gray;
        logic [COMP_W-1:0] l;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/hsl_div255.sv =====
`default_nettype none

module hsl_div255 import hsl_pkg::*; #(
    parameter int IN_W  = 16,
    parameter int OUT_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [IN_W-1:0]  i_x,
    output logic      [OUT_W-1:0] o_q
);

    // floor(x / 255) by reciprocal multiply; exact for x * 127 < 2^SHIFT
    localparam int SHIFT = IN_W + 7;
    localparam longint unsigned MAGIC =
        ((longint'(1) << SHIFT) + longint'(DIV_BASE - 1)) / longint'(DIV_BASE);
    localparam int PROD_W = 2 * IN_W;

    logic [PROD_W-1:0] n_prod;
    logic [OUT_W-1:0]  r_q;

    assign n_prod = PROD_W'(i_x) * PROD_W'(MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_prod[SHIFT +: OUT_W];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/hsl_to_rgb_converter_top.sv =====
`default_nettype none

// 8-bit HSL to BGR colour converter. One transaction carries hue, saturation and
// lightness in, one carries blue, green and red out. A pixel may be accepted every
// clock while o_stall is low; its result passes through the seven register stages
// (peak, min/span, ramp product, numerators, two reciprocal divides by 255, colour
// select), the first of which loads at the accepting edge and the last of which is
// the output register. Results are the exact integer value truncated, so
// they can sit one below a floating-point conversion.
// Hue 255 and lightness 0 give grey (all components equal lightness). A stall on
// the output holds only the stages that are full; bubbles ahead of it still close.

module hsl_to_rgb_converter_top import hsl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [COMP_W-1:0] i_hue,
    input  wire logic [COMP_W-1:0] i_saturation,
    input  wire logic [COMP_W-1:0] i_lightness,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [COMP_W-1:0] o_blue,
    output logic      [COMP_W-1:0] o_green,
    output logic      [COMP_W-1:0] o_red
);

    localparam int NSTG = 7;

    logic [NSTG:1] r_v;
    logic [NSTG:1] en;

    always_comb begin
        en[NSTG] = !r_v[NSTG] || !i_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[NSTG];

    // stage 1: peak, sextant, fraction
    logic [PV_W-1:0]   n1_ls;
    logic [PV_W:0]     n1_pv;
    logic [H6_W-1:0]   n1_h6;
    logic [SX_W-1:0]   n1_sx;
    logic [H6_W-1:0]   n1_base;
    logic [H6_W-1:0]   n1_fr;
    logic [PV_W-1:0]   r1_pv;
    logic [COMP_W-1:0] r1_l;
    logic [SX_W-1:0]   r1_sx;
    logic [COMP_W-1:0] r1_fr;

    always_comb begin
        n1_ls = PV_W'(i_lightness) * PV_W'(i_saturation);
        if (i_lightness <= COMP_W'(127)) begin
            n1_pv = (17'(i_lightness) << 8) - 17'(i_lightness) + 17'(n1_ls);
        end else begin
            n1_pv = 17'(DIV_BASE) * (17'(i_lightness) + 17'(i_saturation)) - 17'(n1_ls);
        end
        n1_h6 = (H6_W'(i_hue) << 2) + (H6_W'(i_hue) << 1);
        if (n1_h6 >= H6_W'(6 * DIV_BASE)) begin
            n1_sx = SX_GRAY;
        end else if (n1_h6 >= H6_W'(5 * DIV_BASE)) begin
            n1_sx = SX_RED_TOP;
        end else if (n1_h6 >= H6_W'(4 * DIV_BASE)) begin
            n1_sx = SX_RED_RISE;
        end else if (n1_h6 >= H6_W'(3 * DIV_BASE)) begin
            n1_sx = SX_BLUE_TOP;
        end else if (n1_h6 >= H6_W'(2 * DIV_BASE)) begin
            n1_sx = SX_BLUE_UP;
        end else if (n1_h6 >= H6_W'(DIV_BASE)) begin
            n1_sx = SX_GREEN_TOP;
        end else begin
            n1_sx = SX_RED_UP;
        end
        n1_base = H6_W'(n1_sx) * H6_W'(DIV_BASE);
        n1_fr   = n1_h6 - n1_base;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_pv <= n1_pv[PV_W-1:0];
            r1_l  <= i_lightness;
            r1_sx <= n1_sx;
            r1_fr <= n1_fr[COMP_W-1:0];
        end
    end

    // stage 2: minimum and span
    logic [17:0]       n2_l510;
    logic [17:0]       n2_mn;
    logic [17:0]       n2_d;
    logic [PV_W-1:0]   r2_pv;
    logic [PV_W-1:0]   r2_mn;
    logic [PV_W-1:0]   r2_d;
    logic [COMP_W-1:0] r2_fr;
    t_side             r2_sd;

    always_comb begin
        n2_l510 = 18'(r1_l) * 18'd510;
        n2_mn   = n2_l510 - 18'(r1_pv);
        n2_d    = (18'(r1_pv) << 1) - n2_l510;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_pv      <= r1_pv;
            r2_mn      <= n2_mn[PV_W-1:0];
            r2_d       <= n2_d[PV_W-1:0];
            r2_fr      <= r1_fr;
            r2_sd.sx   <= r1_sx;
            r2_sd.gray <= (r1_pv == '0) || (r1_sx == SX_GRAY);
            r2_sd.l    <= r1_l;
        end
    end

    // stage 3: ramp product, scaled extremes, peak and min components
    logic [NUM_W-1:0]  r3_ramp;
    logic [NUM_W-1:0]  r3_mn255;
    logic [NUM_W-1:0]  r3_pv255;
    logic [COMP_W-1:0] w3_cv;
    logic [COMP_W-1:0] w3_cm;
    t_side             r3_sd;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_ramp  <= NUM_W'(r2_d) * NUM_W'(r2_fr);
            r3_mn255 <= (NUM_W'(r2_mn) << 8) - NUM_W'(r2_mn);
            r3_pv255 <= (NUM_W'(r2_pv) << 8) - NUM_W'(r2_pv);
            r3_sd    <= r2_sd;
        end
    end

    hsl_div255 #(.IN_W(PV_W), .OUT_W(COMP_W)) u_div_cv (
        .i_clk (i_clk),
        .i_en  (en[3]),
        .i_x   (r2_pv),
        .o_q   (w3_cv)
    );

    hsl_div255 #(.IN_W(PV_W), .OUT_W(COMP_W)) u_div_cm (
        .i_clk (i_clk),
        .i_en  (en[3]),
        .i_x   (r2_mn),
        .o_q   (w3_cm)
    );

    // stage 4: ramp numerators
    logic [NUM_W-1:0]  r4_n1;
    logic [NUM_W-1:0]  r4_n2;
    logic [COMP_W-1:0] r4_cv;
    logic [COMP_W-1:0] r4_cm;
    t_side             r4_sd;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_n1 <= r3_mn255 + r3_ramp;
            r4_n2 <= r3_pv255 - r3_ramp;
            r4_cv <= w3_cv;
            r4_cm <= w3_cm;
            r4_sd <= r3_sd;
        end
    end

    // stages 5 and 6: divide by 255 twice
    logic [PV_W-1:0]   w5_t1;
    logic [PV_W-1:0]   w5_t2;
    logic [COMP_W-1:0] r5_cv;
    logic [COMP_W-1:0] r5_cm;
    t_side             r5_sd;
    logic [COMP_W-1:0] w6_c1;
    logic [COMP_W-1:0] w6_c2;
    logic [COMP_W-1:0] r6_cv;
    logic [COMP_W-1:0] r6_cm;
    t_side             r6_sd;

    hsl_div255 #(.IN_W(NUM_W), .OUT_W(PV_W)) u_div_t1 (
        .i_clk (i_clk),
        .i_en  (en[5]),
        .i_x   (r4_n1),
        .o_q   (w5_t1)
    );

    hsl_div255 #(.IN_W(NUM_W), .OUT_W(PV_W)) u_div_t2 (
        .i_clk (i_clk),
        .i_en  (en[5]),
        .i_x   (r4_n2),
        .o_q   (w5_t2)
    );

    hsl_div255 #(.IN_W(PV_W), .OUT_W(COMP_W)) u_div_c1 (
        .i_clk (i_clk),
        .i_en  (en[6]),
        .i_x   (w5_t1),
        .o_q   (w6_c1)
    );

    hsl_div255 #(.IN_W(PV_W), .OUT_W(COMP_W)) u_div_c2 (
        .i_clk (i_clk),
        .i_en  (en[6]),
        .i_x   (w5_t2),
        .o_q   (w6_c2)
    );

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_cv <= r4_cv;
            r5_cm <= r4_cm;
            r5_sd <= r4_sd;
        end
        if (en[6]) begin
            r6_cv <= r5_cv;
            r6_cm <= r5_cm;
            r6_sd <= r5_sd;
        end
    end

    // stage 7: sextant select into the output register
    logic [COMP_W-1:0] n7_r;
    logic [COMP_W-1:0] n7_g;
    logic [COMP_W-1:0] n7_b;
    logic [COMP_W-1:0] r7_r;
    logic [COMP_W-1:0] r7_g;
    logic [COMP_W-1:0] r7_b;

    always_comb begin
        n7_r = r6_sd.l;
        n7_g = r6_sd.l;
        n7_b = r6_sd.l;
        if (!r6_sd.gray) begin
            case (r6_sd.sx)
                SX_RED_UP: begin
                    n7_r = r6_cv; n7_g = w6_c1; n7_b = r6_cm;
                end
                SX_GREEN_TOP: begin
                    n7_r = w6_c2; n7_g = r6_cv; n7_b = r6_cm;
                end
                SX_BLUE_UP: begin
                    n7_r = r6_cm; n7_g = r6_cv; n7_b = w6_c1;
                end
                SX_BLUE_TOP: begin
                    n7_r = r6_cm; n7_g = w6_c2; n7_b = r6_cv;
                end
                SX_RED_RISE: begin
                    n7_r = w6_c1; n7_g = r6_cm; n7_b = r6_cv;
                end
                SX_RED_TOP: begin
                    n7_r = r6_cv; n7_g = r6_cm; n7_b = w6_c2;
                end
                default: begin
                    n7_r = r6_sd.l; n7_g = r6_sd.l; n7_b = r6_sd.l;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_r <= n7_r;
            r7_g <= n7_g;
            r7_b <= n7_b;
        end
    end

    assign o_red   = r7_r;
    assign o_green = r7_g;
    assign o_blue  = r7_b;

endmodule

`default_nettype wire

// ===== sim/tb_hsl_to_rgb_converter_top.sv =====
`timescale 1ns / 100ps

class colour_scoreboard;
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_colour;

    t_colour     pending_colours[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    // exact integer HSL -> RGB, every quantity a numerator over a power of 255
    function t_colour predict_colour(logic [7:0] hue, logic [7:0] sat, logic [7:0] lig);
        int unsigned h, s, l, peak, floor_v, h6, frac, ramp, c_peak, c_min, c_up, c_down;
        logic [hsl_pkg::SX_W-1:0] sextant;
        t_colour c;
        h = 32'(hue);
        s = 32'(sat);
        l = 32'(lig);
        c.red = lig;
        c.green = lig;
        c.blue = lig;
        if (l <= 127) begin
            peak = l * (255 + s);
        end else begin
            peak = 255 * (l + s) - l * s;
        end
        if (peak != 0) begin
            floor_v = 510 * l - peak;
            h6      = 6 * h;
            sextant = hsl_pkg::SX_W'(h6 / 255);
            frac    = h6 % 255;
            ramp    = (peak - floor_v) * frac;
            c_peak  = peak / 255;
            c_min   = floor_v / 255;
            c_up    = (255 * floor_v + ramp) / 65025;
            c_down  = (255 * peak - ramp) / 65025;
            case (sextant)
                hsl_pkg::SX_RED_UP: begin
                    c.red = 8'(c_peak); c.green = 8'(c_up); c.blue = 8'(c_min);
                end
                hsl_pkg::SX_GREEN_TOP: begin
                    c.red = 8'(c_down); c.green = 8'(c_peak); c.blue = 8'(c_min);
                end
                hsl_pkg::SX_BLUE_UP: begin
                    c.red = 8'(c_min); c.green = 8'(c_peak); c.blue = 8'(c_up);
                end
                hsl_pkg::SX_BLUE_TOP: begin
                    c.red = 8'(c_min); c.green = 8'(c_down); c.blue = 8'(c_peak);
                end
                hsl_pkg::SX_RED_RISE: begin
                    c.red = 8'(c_up); c.green = 8'(c_min); c.blue = 8'(c_peak);
                end
                hsl_pkg::SX_RED_TOP: begin
                    c.red = 8'(c_peak); c.green = 8'(c_min); c.blue = 8'(c_down);
                end
                default: begin
                    // hue 255: left grey
                end
            endcase
        end
        return c;
    endfunction

    function void note_pixel(logic [7:0] hue, logic [7:0] sat, logic [7:0] lig);
        pending_colours.push_back(predict_colour(hue, sat, lig));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_colour(logic [7:0] blue, logic [7:0] green, logic [7:0] red);
        t_colour want;
        if (pending_colours.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual b=%0d g=%0d r=%0d",
                     $time, blue, green, red);
            mismatches++;
            return;
        end
        want = pending_colours.pop_front();
        compare_field("blue", want.blue, blue);
        compare_field("green", want.green, green);
        compare_field("red", want.red, red);
    endfunction

    function int pending();
        return pending_colours.size();
    endfunction
endclass

module tb_hsl_to_rgb_converter_top;
    import hsl_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [COMP_W-1:0] i_hue = '0;
    logic [COMP_W-1:0] i_saturation = '0;
    logic [COMP_W-1:0] i_lightness = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [COMP_W-1:0] o_blue;
    logic [COMP_W-1:0] o_green;
    logic [COMP_W-1:0] o_red;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    colour_scoreboard sb = new();

    hsl_to_rgb_converter_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_blue       (o_blue),
        .o_green      (o_green),
        .o_red        (o_red)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_pixel(i_hue, i_saturation, i_lightness);
            end
            if (o_valid && !i_stall) begin
                sb.check_colour(o_blue, o_green, o_red);
            end
        end
    end

    // called just after a falling edge, returns just after the falling edge following acceptance
    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] lig);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid      <= 1'b0;
            i_hue        <= 8'($urandom);
            i_saturation <= 8'($urandom);
            i_lightness  <= 8'($urandom);
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_lightness  <= lig;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [7:0] hue, sat, lig;
        repeat (count) begin
            hue = 8'($urandom);
            sat = 8'($urandom);
            lig = 8'($urandom);
            case ($urandom_range(9))
                0: hue = 8'hff;
                1: begin
                    case ($urandom_range(3))
                        0: lig = 8'd0;
                        1: lig = 8'd127;
                        2: lig = 8'd128;
                        default: lig = 8'd255;
                    endcase
                end
                2: sat = $urandom_range(1) ? 8'hff : 8'h00;
                default: ;
            endcase
            send_pixel(hue, sat, lig);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 87;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd77);
        send_pixel(8'd0, 8'd255, 8'd127);
        send_pixel(8'd0, 8'd255, 8'd128);
        send_pixel(8'd21, 8'd255, 8'd128);
        send_pixel(8'd64, 8'd255, 8'd128);
        send_pixel(8'd106, 8'd255, 8'd128);
        send_pixel(8'd149, 8'd255, 8'd128);
        send_pixel(8'd191, 8'd255, 8'd128);
        send_pixel(8'd234, 8'd255, 8'd128);
        send_pixel(8'd42, 8'd200, 8'd100);
        send_pixel(8'd43, 8'd200, 8'd100);
        send_pixel(8'd85, 8'd170, 8'd60);
        send_pixel(8'd170, 8'd90, 8'd200);
        send_pixel(8'd254, 8'd255, 8'd127);
        send_pixel(8'd100, 8'd0, 8'd200);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd255);
        send_pixel(8'd213, 8'd255, 8'd254);
        send_random(133);
        drain_results();

        send_idle_pct = 87;
        recv_idle_pct = 31;
        @(negedge i_clk);
        send_random(133);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge i_clk);
        send_random(134);
        drain_results();

        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
